/* hdl/vec3_axis_rotation_assert.svh */
// ----------------------------------------------------------------------------
// vec3_axis_rotation assertion macros
// Concurrent assertion shorthands clocked on aclk.
// ----------------------------------------------------------------------------
`ifndef VEC3_AXIS_ROTATION_ASSERT_SVH
`define VEC3_AXIS_ROTATION_ASSERT_SVH
// same-cycle implication, masked while in reset
`define V3ROT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, live during reset
`define V3ROT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* hdl/v3rot_pkg.sv */
// ----------------------------------------------------------------------------
// v3rot_pkg
// Shared types, constants and the arctangent table for the vector rotator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package v3rot_pkg;

    localparam int CORDIC_STEPS_DEF = 18;
    localparam int FRAC_BITS_DEF    = 16;

    localparam int COMP_W = 32;   // Q16.16 component
    localparam int TURN_W = 20;   // input angle
    localparam int IFRAC  = 30;   // internal angle / cos / sin fraction bits
    localparam int ANG_W  = 33;   // folded angle and CORDIC residual
    localparam int CS_W   = 33;   // CORDIC x / y, cos / sin
    localparam int TWO_PI_LOG2 = 32;  // 2^32 <= 2*pi in Q30 < 2^33

    localparam longint PI_Q      = 64'sd3373259426;
    localparam longint HALF_PI_Q = 64'sd1686629713;
    localparam longint TWO_PI_Q  = 64'sd6746518852;
    localparam longint GAIN_Q    = 64'sd652032874;

    typedef enum logic [1:0] {
        MODE_ROT_X = 2'd0,
        MODE_ROT_Y = 2'd1,
        MODE_ROT_Z = 2'd2,
        MODE_PASS  = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t                    mode;
        logic signed [COMP_W-1:0] x;
        logic signed [COMP_W-1:0] y;
        logic signed [COMP_W-1:0] z;
    } vec_t;

    // number of conditional 2*pi subtractions needed for a given angle format
    function automatic int reduce_steps(input int frac_bits);
        int q;
        q = TURN_W - 1 + IFRAC - frac_bits - TWO_PI_LOG2;
        return (q > 1) ? q : 1;
    endfunction

    // atan(2^-i) in Q30
    function automatic logic signed [ANG_W-1:0] atan_q(input int i);
        logic signed [ANG_W-1:0] r;
        case (i)
            0:       r = ANG_W'(843314857);
            1:       r = ANG_W'(497837830);
            2:       r = ANG_W'(263043837);
            3:       r = ANG_W'(133525159);
            4:       r = ANG_W'(67021687);
            5:       r = ANG_W'(33543516);
            6:       r = ANG_W'(16775851);
            7:       r = ANG_W'(8388437);
            8:       r = ANG_W'(4194283);
            9:       r = ANG_W'(2097149);
            default: r = ANG_W'(1) << (IFRAC - i);
        endcase
        return r;
    endfunction

endpackage

/* hdl/v3rot_angle.sv */
// ----------------------------------------------------------------------------
// v3rot_angle
// Angle reduction pipeline: modulo 2*pi, wrap into [-pi, pi], quadrant fold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module v3rot_angle #(
    parameter int FRAC_BITS = v3rot_pkg::FRAC_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  v3rot_pkg::vec_t                       in_vec,
    input  logic signed [v3rot_pkg::TURN_W-1:0]   in_turn,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output v3rot_pkg::vec_t                       out_vec,
    output logic signed [v3rot_pkg::ANG_W-1:0]    out_ang,
    output logic                                  out_neg
);
    import v3rot_pkg::*;

    localparam int SHIFT  = IFRAC - FRAC_BITS;
    localparam int MAG_W0 = TURN_W + SHIFT;
    localparam int MAG_W  = (MAG_W0 > 34) ? MAG_W0 : 34;
    localparam int QB     = reduce_steps(FRAC_BITS);
    localparam int NS     = QB + 4;
    localparam int TP_W   = 33;
    localparam int RW     = 34;

    localparam logic signed [RW-1:0] PI_R      = RW'(PI_Q);
    localparam logic signed [RW-1:0] HALF_PI_R = RW'(HALF_PI_Q);
    localparam logic signed [RW-1:0] TWO_PI_R  = RW'(TWO_PI_Q);

    logic                     en;
    logic [NS-1:0]            v_reg;
    vec_t                     vec_reg [NS];
    logic [MAG_W-1:0]         mag_reg  [QB+1];
    logic [MAG_W-1:0]         mag_next [QB+1];
    logic                     sgn_reg  [QB+1];
    logic [TURN_W-1:0]        turn_abs;
    logic signed [RW-1:0]     a1_reg, a1_next;
    logic signed [RW-1:0]     a2_reg, a2_next;
    logic signed [ANG_W-1:0]  a3_reg, a3_next;
    logic                     neg_reg, neg_next;

    assign en       = !v_reg[NS-1] || out_ready;
    assign in_ready = en;

    assign turn_abs    = in_turn[TURN_W-1] ? TURN_W'(-in_turn) : TURN_W'(in_turn);
    assign mag_next[0] = MAG_W'({turn_abs, {SHIFT{1'b0}}});

    // restoring reduction, largest multiple of 2*pi first
    for (genvar j = 0; j < QB; j++) begin : g_mod
        localparam logic [MAG_W-1:0] STEP_C = MAG_W'(TWO_PI_Q) << (QB - 1 - j);
        assign mag_next[j+1] = (mag_reg[j] >= STEP_C) ? mag_reg[j] - STEP_C : mag_reg[j];
    end

    assign a1_next = sgn_reg[QB] ? -$signed({1'b0, mag_reg[QB][TP_W-1:0]})
                                 :  $signed({1'b0, mag_reg[QB][TP_W-1:0]});

    always_comb begin
        if (a1_reg > PI_R) begin
            a2_next = a1_reg - TWO_PI_R;
        end else if (a1_reg < -PI_R) begin
            a2_next = a1_reg + TWO_PI_R;
        end else begin
            a2_next = a1_reg;
        end
    end

    always_comb begin
        if (a2_reg > HALF_PI_R) begin
            a3_next  = ANG_W'(a2_reg - PI_R);
            neg_next = 1'b1;
        end else if (a2_reg < -HALF_PI_R) begin
            a3_next  = ANG_W'(a2_reg + PI_R);
            neg_next = 1'b1;
        end else begin
            a3_next  = ANG_W'(a2_reg);
            neg_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vec_reg[0] <= in_vec;
            for (int k = 1; k < NS; k++) begin
                vec_reg[k] <= vec_reg[k-1];
            end
            sgn_reg[0] <= in_turn[TURN_W-1];
            for (int j = 1; j <= QB; j++) begin
                sgn_reg[j] <= sgn_reg[j-1];
            end
            for (int j = 0; j <= QB; j++) begin
                mag_reg[j] <= mag_next[j];
            end
            a1_reg  <= a1_next;
            a2_reg  <= a2_next;
            a3_reg  <= a3_next;
            neg_reg <= neg_next;
        end
    end

    assign out_valid = v_reg[NS-1];
    assign out_vec   = vec_reg[NS-1];
    assign out_ang   = a3_reg;
    assign out_neg   = neg_reg;

endmodule

/* hdl/v3rot_cordic.sv */
// ----------------------------------------------------------------------------
// v3rot_cordic
// Unrolled rotation-mode CORDIC, one register stage per iteration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module v3rot_cordic #(
    parameter int CORDIC_STEPS = v3rot_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  v3rot_pkg::vec_t                       in_vec,
    input  logic signed [v3rot_pkg::ANG_W-1:0]    in_ang,
    input  logic                                  in_neg,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output v3rot_pkg::vec_t                       out_vec,
    output logic signed [v3rot_pkg::CS_W-1:0]     out_cos,
    output logic signed [v3rot_pkg::CS_W-1:0]     out_sin
);
    import v3rot_pkg::*;

    localparam int N  = CORDIC_STEPS;
    localparam int NS = N + 1;

    localparam logic signed [CS_W-1:0] GAIN_C = CS_W'(GAIN_Q);

    logic                     en;
    logic [NS-1:0]            v_reg;
    vec_t                     vec_reg [NS];
    logic                     neg_reg [N];
    logic signed [CS_W-1:0]   x_reg [N];
    logic signed [CS_W-1:0]   x_next [N];
    logic signed [CS_W-1:0]   y_reg [N];
    logic signed [CS_W-1:0]   y_next [N];
    logic signed [ANG_W-1:0]  a_reg [N];
    logic signed [ANG_W-1:0]  a_next [N];
    logic signed [CS_W-1:0]   c_reg, c_next;
    logic signed [CS_W-1:0]   s_reg, s_next;

    assign en       = !v_reg[NS-1] || out_ready;
    assign in_ready = en;

    for (genvar i = 0; i < N; i++) begin : g_iter
        localparam logic signed [ANG_W-1:0] ATAN_C = atan_q(i);
        logic signed [CS_W-1:0]  xi, yi;
        logic signed [ANG_W-1:0] ai;
        logic                    up;
        if (i == 0) begin : g_first
            assign xi = GAIN_C;
            assign yi = '0;
            assign ai = in_ang;
        end else begin : g_rest
            assign xi = x_reg[i-1];
            assign yi = y_reg[i-1];
            assign ai = a_reg[i-1];
        end
        assign up        = !ai[ANG_W-1];
        assign x_next[i] = up ? xi - (yi >>> i) : xi + (yi >>> i);
        assign y_next[i] = up ? yi + (xi >>> i) : yi - (xi >>> i);
        assign a_next[i] = up ? ai - ATAN_C : ai + ATAN_C;
    end

    assign c_next = neg_reg[N-1] ? -x_reg[N-1] : x_reg[N-1];
    assign s_next = neg_reg[N-1] ? -y_reg[N-1] : y_reg[N-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vec_reg[0] <= in_vec;
            neg_reg[0] <= in_neg;
            for (int k = 1; k < NS; k++) begin
                vec_reg[k] <= vec_reg[k-1];
            end
            for (int k = 1; k < N; k++) begin
                neg_reg[k] <= neg_reg[k-1];
            end
            for (int k = 0; k < N; k++) begin
                x_reg[k] <= x_next[k];
                y_reg[k] <= y_next[k];
                a_reg[k] <= a_next[k];
            end
            c_reg <= c_next;
            s_reg <= s_next;
        end
    end

    assign out_valid = v_reg[NS-1];
    assign out_vec   = vec_reg[NS-1];
    assign out_cos   = c_reg;
    assign out_sin   = s_reg;

endmodule

/* hdl/v3rot_rotate.sv */
// ----------------------------------------------------------------------------
// v3rot_rotate
// Plane rotation: operand select, products, rounding and saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module v3rot_rotate (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  v3rot_pkg::vec_t                       in_vec,
    input  logic signed [v3rot_pkg::CS_W-1:0]     in_cos,
    input  logic signed [v3rot_pkg::CS_W-1:0]     in_sin,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [v3rot_pkg::COMP_W-1:0]   out_x,
    output logic signed [v3rot_pkg::COMP_W-1:0]   out_y,
    output logic signed [v3rot_pkg::COMP_W-1:0]   out_z
);
    import v3rot_pkg::*;

    localparam int NS  = 3;
    localparam int PW  = COMP_W + CS_W;
    localparam int SW  = PW + 1;
    localparam int RW2 = SW - IFRAC;

    localparam logic signed [SW-1:0]  RND  = SW'(64'sd1 << (IFRAC - 1));
    localparam logic signed [RW2-1:0] R_HI = RW2'(64'sd2147483647);
    localparam logic signed [RW2-1:0] R_LO = -R_HI - RW2'(1);

    function automatic logic signed [COMP_W-1:0] sat_c(input logic signed [RW2-1:0] v);
        logic signed [COMP_W-1:0] r;
        if (v > R_HI) begin
            r = {1'b0, {(COMP_W-1){1'b1}}};
        end else if (v < R_LO) begin
            r = {1'b1, {(COMP_W-1){1'b0}}};
        end else begin
            r = COMP_W'(v);
        end
        return r;
    endfunction

    logic                      en;
    logic [NS-1:0]             v_reg;
    vec_t                      vec_reg [NS-1];
    logic signed [COMP_W-1:0]  op_a, op_b;
    logic signed [PW-1:0]      ac_reg, bs_reg, as_reg, bc_reg;
    logic signed [PW-1:0]      ac_next, bs_next, as_next, bc_next;
    logic signed [SW-1:0]      sc_reg, sc_next;
    logic signed [SW-1:0]      ss_reg, ss_next;
    logic signed [COMP_W-1:0]  rc, rs;
    logic signed [COMP_W-1:0]  ox_reg, oy_reg, oz_reg;
    logic signed [COMP_W-1:0]  ox_next, oy_next, oz_next;

    assign en       = !v_reg[NS-1] || out_ready;
    assign in_ready = en;

    always_comb begin
        case (in_vec.mode)
            MODE_ROT_X: begin
                op_a = in_vec.y;
                op_b = in_vec.z;
            end
            MODE_ROT_Y: begin
                op_a = in_vec.x;
                op_b = in_vec.z;
            end
            default: begin
                op_a = in_vec.x;
                op_b = in_vec.y;
            end
        endcase
    end

    assign ac_next = op_a * in_cos;
    assign bs_next = op_b * in_sin;
    assign as_next = op_a * in_sin;
    assign bc_next = op_b * in_cos;

    assign sc_next = SW'(ac_reg) - SW'(bs_reg) + RND;
    assign ss_next = SW'(as_reg) + SW'(bc_reg) + RND;

    assign rc = sat_c($signed(sc_reg[SW-1:IFRAC]));
    assign rs = sat_c($signed(ss_reg[SW-1:IFRAC]));

    always_comb begin
        ox_next = vec_reg[1].x;
        oy_next = vec_reg[1].y;
        oz_next = vec_reg[1].z;
        case (vec_reg[1].mode)
            MODE_ROT_X: begin
                oy_next = rc;
                oz_next = rs;
            end
            MODE_ROT_Y: begin
                ox_next = rc;
                oz_next = rs;
            end
            MODE_ROT_Z: begin
                ox_next = rc;
                oy_next = rs;
            end
            default: begin
                ox_next = vec_reg[1].x;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vec_reg[0] <= in_vec;
            vec_reg[1] <= vec_reg[0];
            ac_reg     <= ac_next;
            bs_reg     <= bs_next;
            as_reg     <= as_next;
            bc_reg     <= bc_next;
            sc_reg     <= sc_next;
            ss_reg     <= ss_next;
            ox_reg     <= ox_next;
            oy_reg     <= oy_next;
            oz_reg     <= oz_next;
        end
    end

    assign out_valid = v_reg[NS-1];
    assign out_x     = ox_reg;
    assign out_y     = oy_reg;
    assign out_z     = oz_reg;

endmodule

/* hdl/vec3_axis_rotation.sv */
// ----------------------------------------------------------------------------
// vec3_axis_rotation
// Rotates a Q16.16 3D vector about the x, y or z axis by a radian angle.
//
// Usage:
//   s_axis carries one vector, its angle and the axis select per transfer;
//   m_axis returns the rotated vector, one transfer for each input transfer,
//   in order. Axis select 3 passes the vector through unchanged.
//   Throughput is one transfer per clock while m_axis_tready stays high.
//   The pipeline is the angle reduction stages, with R = max(1, 17 - FRAC_BITS)
//   conditional 2*pi subtractions, then the unrolled CORDIC, one register
//   stage per iteration, then three multiply / round stages.
//   Reset (aresetn low, synchronous) empties the pipeline; no transfer is
//   presented until new input arrives.
//   When m_axis_tready is low with a result waiting, the output stage holds;
//   sections upstream keep moving until their own last stage is occupied,
//   and s_axis_tready drops once the angle section cannot hand on its item;
//   nothing is lost or duplicated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "vec3_axis_rotation_assert.svh"

module vec3_axis_rotation #(
    parameter int CORDIC_STEPS = v3rot_pkg::CORDIC_STEPS_DEF,
    parameter int FRAC_BITS    = v3rot_pkg::FRAC_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // in_x [31:0], in_y [63:32], in_z [95:64], turn_angle [115:96], zero pad
    input  logic [119:0] s_axis_tdata,
    // mode [1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_x [31:0], out_y [63:32], out_z [95:64]
    output logic [95:0]  m_axis_tdata
);
    import v3rot_pkg::*;

    localparam int LAT   = (reduce_steps(FRAC_BITS) + 4) + (CORDIC_STEPS + 1) + 3;
    localparam int OCC_W = $clog2(LAT + 1);

    vec_t                     in_vec;
    logic signed [TURN_W-1:0] in_turn;

    logic                     a_valid, a_ready;
    vec_t                     a_vec;
    logic signed [ANG_W-1:0]  a_ang;
    logic                     a_neg;

    logic                     c_valid, c_ready;
    vec_t                     c_vec;
    logic signed [CS_W-1:0]   c_cos, c_sin;

    logic signed [COMP_W-1:0] o_x, o_y, o_z;

    logic [OCC_W-1:0]         occ_reg, occ_next;
    logic                     occ_ok;

    assign in_vec.mode = mode_t'(s_axis_tuser);
    assign in_vec.x    = $signed(s_axis_tdata[31:0]);
    assign in_vec.y    = $signed(s_axis_tdata[63:32]);
    assign in_vec.z    = $signed(s_axis_tdata[95:64]);
    assign in_turn     = $signed(s_axis_tdata[115:96]);

    v3rot_angle #(
        .FRAC_BITS (FRAC_BITS)
    ) u_angle (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_vec    (in_vec),
        .in_turn   (in_turn),
        .out_valid (a_valid),
        .out_ready (a_ready),
        .out_vec   (a_vec),
        .out_ang   (a_ang),
        .out_neg   (a_neg)
    );

    v3rot_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (a_valid),
        .in_ready  (a_ready),
        .in_vec    (a_vec),
        .in_ang    (a_ang),
        .in_neg    (a_neg),
        .out_valid (c_valid),
        .out_ready (c_ready),
        .out_vec   (c_vec),
        .out_cos   (c_cos),
        .out_sin   (c_sin)
    );

    v3rot_rotate u_rotate (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (c_valid),
        .in_ready  (c_ready),
        .in_vec    (c_vec),
        .in_cos    (c_cos),
        .in_sin    (c_sin),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_x     (o_x),
        .out_y     (o_y),
        .out_z     (o_z)
    );

    assign m_axis_tdata = {o_z, o_y, o_x};

    // transfers in flight, for checking only
    always_comb begin
        occ_next = occ_reg;
        if ((s_axis_tvalid && s_axis_tready) && !(m_axis_tvalid && m_axis_tready)) begin
            occ_next = occ_reg + OCC_W'(1);
        end else if (!(s_axis_tvalid && s_axis_tready) && (m_axis_tvalid && m_axis_tready)) begin
            occ_next = occ_reg - OCC_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    assign occ_ok = (occ_reg != '0) && (occ_reg <= OCC_W'(LAT));

    `V3ROT_ASSERT_NOW(a_ready_when_drained, m_axis_tready, s_axis_tready, "stall with output free")
    `V3ROT_ASSERT_NEXT(a_reset_empties, !aresetn, !m_axis_tvalid, "result after reset")
    `V3ROT_ASSERT_NOW(a_occupancy, m_axis_tvalid, occ_ok, "result without matching input")

endmodule
